FILE: hw/rtl/odbp_pkg.sv
// odbp_pkg: shared constants, types and the halftone-dot table for the
// ordered-dither bit packer; no dependencies
package odbp_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int WIDTH_W = 13;
  localparam int COL_W = $clog2(MAX_ROW_PIXELS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(1728);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_MAX = WIDTH_W'(MAX_ROW_PIXELS);
  localparam logic [6:0] SCALED_WHITE = 7'd64;
  localparam logic [7:0] MSB_BIT = 8'h80;
  localparam logic [2:0] LAST_BIT_POS = 3'd7;

  localparam logic [5:0] DOT_MATRIX [8][8] = '{
    '{6'd3,  6'd17, 6'd55, 6'd63, 6'd61, 6'd47, 6'd9,  6'd1 },
    '{6'd15, 6'd29, 6'd39, 6'd51, 6'd49, 6'd35, 6'd25, 6'd13},
    '{6'd40, 6'd32, 6'd26, 6'd20, 6'd22, 6'd30, 6'd36, 6'd42},
    '{6'd56, 6'd44, 6'd10, 6'd4,  6'd6,  6'd18, 6'd52, 6'd58},
    '{6'd60, 6'd46, 6'd8,  6'd0,  6'd2,  6'd16, 6'd54, 6'd62},
    '{6'd48, 6'd34, 6'd24, 6'd12, 6'd14, 6'd28, 6'd38, 6'd50},
    '{6'd23, 6'd31, 6'd37, 6'd43, 6'd41, 6'd33, 6'd27, 6'd21},
    '{6'd7,  6'd19, 6'd53, 6'd59, 6'd57, 6'd45, 6'd11, 6'd5 }
  };

  typedef struct packed {
    logic black;
    logic last;
  } odbp_cmd_t;

endpackage

FILE: hw/rtl/ordered_dither_bit_pack_unit.sv
// ordered_dither_bit_pack_unit: top level of the ordered-dither bit packer
// depends on odbp_pkg, odbp_front, odbp_queue, odbp_back
//
// usage:
//   input side is a queue write port: a pixel (gray, page_start) transfers
//   on a rising edge with push high and full low. pixels come in raster order.
//   result side is a queue read port: while empty is low, packed_byte and
//   row_end show the oldest byte; it transfers on an edge with pop high.
//   wr_en/wr_data write row_width at any edge; write it only while idle.
//   a byte is produced after eight pixels or at the last pixel of a row.
// timing:
//   one pixel per cycle while full is low. the byte completed by a pixel is
//   dithered into the command queue at that pixel's transfer, then packed
//   into the output register, from which it appears on the result ports.
//   a four-entry command queue sits between dither and pack; when pop stays
//   low the output register holds, the queue fills and full rises.
// reset:
//   rst (synchronous) sets row_width to 1728, clears counters, queue and
//   output valid flag; empty is high and full low after reset.
module ordered_dither_bit_pack_unit import odbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         gray,
  input  logic               page_start,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         packed_byte,
  output logic               row_end,
  input  logic               wr_en,
  input  logic [WIDTH_W-1:0] wr_data
);

  odbp_cmd_t front_cmd;
  odbp_cmd_t back_cmd;
  logic      accept;
  logic      q_empty;
  logic      q_pop;

  assign accept = push && !full;

  odbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .gray       (gray),
    .page_start (page_start),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .cmd        (front_cmd)
  );

  odbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .cmd_in  (front_cmd),
    .full    (full),
    .pop     (q_pop),
    .cmd_out (back_cmd),
    .empty   (q_empty)
  );

  odbp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (back_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .packed_byte (packed_byte),
    .row_end     (row_end)
  );

endmodule

FILE: hw/rtl/odbp_front.sv
// odbp_front: accepts pixels, tracks column and row phase, dithers each pixel
// into a black/last command; depends on odbp_pkg
module odbp_front import odbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         gray,
  input  logic               page_start,
  input  logic               wr_en,
  input  logic [WIDTH_W-1:0] wr_data,
  output odbp_cmd_t          cmd
);

  logic [WIDTH_W-1:0] row_width;
  logic [COL_W-1:0]   column_count;
  logic [2:0]         row_phase;

  logic [COL_W-1:0]   wm1;
  logic [COL_W-1:0]   col;
  logic [2:0]         phase;
  logic [2:0]         col_sel;
  logic [5:0]         entry;
  logic [14:0]        prod;
  logic [14:0]        qsum;
  logic [6:0]         scaled;
  logic               last;
  logic               white;

  always_comb begin
    if (row_width == '0) begin
      wm1 = '0;
    end else if (row_width > ROW_WIDTH_MAX) begin
      wm1 = COL_W'(MAX_ROW_PIXELS - 1);
    end else begin
      wm1 = COL_W'(row_width - WIDTH_W'(1));
    end
    col = (column_count > wm1) ? wm1 : column_count;
    last = (col == wm1);
    phase = page_start ? 3'd0 : row_phase;
    col_sel = wm1[2:0] - col[2:0];
    entry = DOT_MATRIX[phase][col_sel];
    // exact divide by 255 for values below 2^16
    prod = 15'(gray) * 15'd65;
    qsum = prod + (prod >> 8) + 15'd1;
    scaled = qsum[14:8];
    white = (scaled >= SCALED_WHITE) || (scaled > {1'b0, entry});
    cmd.black = !white;
    cmd.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
      column_count <= '0;
      row_phase <= '0;
    end else begin
      if (wr_en) begin
        row_width <= wr_data;
      end
      if (accept) begin
        if (last) begin
          column_count <= '0;
          row_phase <= phase + 3'd1;
        end else begin
          column_count <= col + COL_W'(1);
          row_phase <= phase;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/odbp_queue.sv
// odbp_queue: short command queue between front and back
// depends on odbp_pkg
module odbp_queue import odbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  odbp_cmd_t cmd_in,
  output logic      full,
  input  logic      pop,
  output odbp_cmd_t cmd_out,
  output logic      empty
);

  odbp_cmd_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/odbp_back.sv
// odbp_back: packs dithered bits msb first and holds the output byte register
// depends on odbp_pkg
module odbp_back import odbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  odbp_cmd_t cmd,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output logic [7:0] packed_byte,
  output logic      row_end
);

  logic [7:0] bit_accumulator;
  logic [2:0] bit_position;
  logic       out_valid;
  logic       out_take;
  logic       emit;
  logic [7:0] acc_next;

  assign out_take = pop && out_valid;
  assign emit = cmd.last || (bit_position == LAST_BIT_POS);
  assign q_pop = !q_empty && (!emit || !out_valid || out_take);
  assign acc_next = bit_accumulator | (cmd.black ? (MSB_BIT >> bit_position) : 8'h00);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      bit_position <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        if (emit) begin
          bit_accumulator <= '0;
          bit_position <= '0;
        end else begin
          bit_accumulator <= acc_next;
          bit_position <= bit_position + 3'd1;
        end
      end
      out_valid <= (out_valid && !out_take) || (q_pop && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      packed_byte <= acc_next;
      row_end <= cmd.last;
    end
  end

endmodule

FILE: hw/rtl/odbp_checker.sv
// odbp_checker: port-level assertions for ordered_dither_bit_pack_unit
// bound to the top level; depends on odbp_pkg
module odbp_checker import odbp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         packed_byte,
  input logic               row_end
);

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queue not idle after reset");

  // the queue only fills up through an input transfer
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transfer");

  // a waiting byte holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(packed_byte) && $stable(row_end)))
    else $error("waiting result changed before transfer");

endmodule

bind ordered_dither_bit_pack_unit odbp_checker u_odbp_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .packed_byte (packed_byte),
  .row_end     (row_end)
);
